// ----- sv/vea_pkg.sv -----
package vea_pkg;

    localparam int DW = 32;
    localparam int FB = 16;
    localparam int QW = DW + FB;
    localparam int PW = 2 * DW;

    localparam logic [DW-1:0] MAX_VAL = {1'b0, {(DW - 1){1'b1}}};
    localparam logic [DW-1:0] MIN_VAL = {1'b1, {(DW - 1){1'b0}}};

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        REG_OPERATION    = 2'd0,
        REG_OPERAND_MODE = 2'd1,
        REG_SCALAR_VALUE = 2'd2
    } reg_index_t;

    typedef struct packed {
        op_t             op;
        logic            last;
        logic            neg;
        logic            flag;
        logic            div_zero;
        logic [DW-1:0]   res;
        logic [DW-1:0]   divisor;
        logic [DW:0]     rem;
        logic [QW-1:0]   quo;
    } pipe_t;

endpackage

// ----- sv/vea_div_step.sv -----
module vea_div_step
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           in_valid,
    input  vea_pkg::pipe_t in_item,
    output logic           out_valid,
    output vea_pkg::pipe_t out_item
);
    import vea_pkg::*;

    logic          valid_reg;
    pipe_t         item_reg;
    pipe_t         item_next;
    logic [DW:0]   rem_sh;
    logic [DW:0]   dvs;
    logic          take;

    // One restoring step: shift in the next dividend bit, subtract if it fits.
    always_comb
    begin
        rem_sh = {in_item.rem[DW-1:0], in_item.quo[QW-1]};
        dvs = {1'b0, in_item.divisor};
        take = (rem_sh >= dvs);
        item_next = in_item;
        item_next.rem = take ? (rem_sh - dvs) : rem_sh;
        item_next.quo = {in_item.quo[QW-2:0], take};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

// ----- sv/vector_elementwise_arith.sv -----
// Throughput: one element per cycle; the divider is a chain of 48 one-bit
// restoring stages, so every operation passes through the same pipeline.
// The whole pipeline stalls only while the output register holds a result
// that is not taken. Reset clears all valid bits and the configuration.
module vector_elementwise_arith
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,  // left_element [31:0], right_element [63:32]
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,  // result_element [31:0]
    output logic        m_axis_tuser,  // saturated [0]
    output logic        m_axis_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import vea_pkg::*;

    logic en;

    op_t           operation_reg;
    logic          operand_mode_reg;
    logic [DW-1:0] scalar_reg;

    logic          v0_reg;
    op_t           op0_reg;
    logic          last0_reg;
    logic [DW-1:0] a0_reg;
    logic [DW-1:0] b0_reg;

    logic          v1_reg;
    op_t           op1_reg;
    logic          last1_reg;
    logic          na1_reg;
    logic          neg1_reg;
    logic          flag1_reg;
    logic [DW-1:0] res1_reg;
    logic [DW-1:0] ma1_reg;
    logic [DW-1:0] mb1_reg;
    logic          flag1_next;
    logic [DW-1:0] res1_next;
    logic [DW-1:0] ma1_next;
    logic [DW-1:0] mb1_next;
    logic [DW:0]   sum1;

    logic          v2_reg;
    op_t           op2_reg;
    logic          last2_reg;
    logic          na2_reg;
    logic          neg2_reg;
    logic          flag2_reg;
    logic [DW-1:0] res2_reg;
    logic [DW-1:0] ma2_reg;
    logic [DW-1:0] mb2_reg;
    logic [PW-1:0] prod2_reg;

    logic          v3_reg;
    pipe_t         s3_reg;
    pipe_t         s3_next;
    logic [PW-1:0] shifted;
    logic [PW-1:0] plim;

    logic          dv_valid [0:QW];
    pipe_t         dv_item [0:QW];

    logic          out_valid_reg;
    logic [DW-1:0] out_res_reg;
    logic          out_flag_reg;
    logic          out_last_reg;
    logic [DW-1:0] out_res_next;
    logic          out_flag_next;
    logic [QW-1:0] qlim;

    assign en = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = en;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            operation_reg    <= OP_ADD;
            operand_mode_reg <= 1'b0;
            scalar_reg       <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_OPERATION:    operation_reg    <= op_t'(cfg_data[1:0]);
                REG_OPERAND_MODE: operand_mode_reg <= cfg_data[0];
                REG_SCALAR_VALUE: scalar_reg       <= cfg_data[DW-1:0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg        <= 1'b0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v0_reg        <= s_axis_tvalid;
            v1_reg        <= v0_reg;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            out_valid_reg <= dv_valid[QW];
        end
    end

    // Stage 1: magnitudes and the saturating add or subtract.
    always_comb
    begin
        if (op0_reg == OP_SUB)
        begin
            sum1 = {a0_reg[DW-1], a0_reg} - {b0_reg[DW-1], b0_reg};
        end
        else
        begin
            sum1 = {a0_reg[DW-1], a0_reg} + {b0_reg[DW-1], b0_reg};
        end
        flag1_next = (sum1[DW] != sum1[DW-1]);
        if (flag1_next)
        begin
            res1_next = a0_reg[DW-1] ? MIN_VAL : MAX_VAL;
        end
        else
        begin
            res1_next = sum1[DW-1:0];
        end
        ma1_next = a0_reg[DW-1] ? (DW'(0) - a0_reg) : a0_reg;
        mb1_next = b0_reg[DW-1] ? (DW'(0) - b0_reg) : b0_reg;
    end

    // Stage 3: scale and saturate the product, set up the divider.
    always_comb
    begin
        shifted = prod2_reg >> FB;
        plim = neg2_reg ? PW'(MIN_VAL) : PW'(MAX_VAL);
        s3_next.op       = op2_reg;
        s3_next.last     = last2_reg;
        s3_next.neg      = neg2_reg;
        s3_next.flag     = flag2_reg;
        s3_next.div_zero = (mb2_reg == '0);
        s3_next.res      = res2_reg;
        s3_next.divisor  = mb2_reg;
        s3_next.rem      = '0;
        s3_next.quo      = QW'(ma2_reg) << FB;
        case (op2_reg)
            OP_MUL:
            begin
                if (shifted > plim)
                begin
                    s3_next.flag = 1'b1;
                    s3_next.res  = neg2_reg ? MIN_VAL : MAX_VAL;
                end
                else
                begin
                    s3_next.flag = 1'b0;
                    s3_next.res  = neg2_reg ? (DW'(0) - shifted[DW-1:0]) : shifted[DW-1:0];
                end
            end
            OP_DIV:
            begin
                s3_next.flag = s3_next.div_zero;
                if (ma2_reg == '0)
                begin
                    s3_next.res = '0;
                end
                else
                begin
                    s3_next.res = na2_reg ? MIN_VAL : MAX_VAL;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            op0_reg   <= operation_reg;
            last0_reg <= s_axis_tlast;
            a0_reg    <= s_axis_tdata[DW-1:0];
            b0_reg    <= operand_mode_reg ? s_axis_tdata[2*DW-1:DW] : scalar_reg;

            op1_reg   <= op0_reg;
            last1_reg <= last0_reg;
            na1_reg   <= a0_reg[DW-1];
            neg1_reg  <= a0_reg[DW-1] ^ b0_reg[DW-1];
            flag1_reg <= flag1_next;
            res1_reg  <= res1_next;
            ma1_reg   <= ma1_next;
            mb1_reg   <= mb1_next;

            op2_reg   <= op1_reg;
            last2_reg <= last1_reg;
            na2_reg   <= na1_reg;
            neg2_reg  <= neg1_reg;
            flag2_reg <= flag1_reg;
            res2_reg  <= res1_reg;
            ma2_reg   <= ma1_reg;
            mb2_reg   <= mb1_reg;
            prod2_reg <= ma1_reg * mb1_reg;

            s3_reg    <= s3_next;

            out_res_reg  <= out_res_next;
            out_flag_reg <= out_flag_next;
            out_last_reg <= dv_item[QW].last;
        end
    end

    assign dv_valid[0] = v3_reg;
    assign dv_item[0]  = s3_reg;

    for (genvar i = 0; i < QW; i++)
    begin : g_div
        vea_div_step u_step
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (dv_valid[i]),
            .in_item   (dv_item[i]),
            .out_valid (dv_valid[i+1]),
            .out_item  (dv_item[i+1])
        );
    end

    // Final stage: saturate and sign the quotient; other results pass through.
    always_comb
    begin
        qlim = dv_item[QW].neg ? QW'(MIN_VAL) : QW'(MAX_VAL);
        out_res_next  = dv_item[QW].res;
        out_flag_next = dv_item[QW].flag;
        if (dv_item[QW].op == OP_DIV && !dv_item[QW].div_zero)
        begin
            if (dv_item[QW].quo > qlim)
            begin
                out_flag_next = 1'b1;
                out_res_next  = dv_item[QW].neg ? MIN_VAL : MAX_VAL;
            end
            else
            begin
                out_flag_next = 1'b0;
                out_res_next  = dv_item[QW].neg ? (DW'(0) - dv_item[QW].quo[DW-1:0])
                                                : dv_item[QW].quo[DW-1:0];
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_res_reg;
    assign m_axis_tuser  = out_flag_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule
